>>> rtl/mtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared types, codes and tables for the MUS to MIDI track converter.
// ----------------------------------------------------------------------------
package mtm_pkg;

  // Time queue width limits and variable-length quantity layout
  localparam int unsigned TIME_WIDTH_DEF = 28;
  localparam int unsigned VLQ_W          = 28;
  localparam int unsigned VLQ_BITS       = 7;
  localparam int unsigned VLQ_GROUPS     = 4;

  // Burst buffer between parser and serializer
  localparam int unsigned BURST_DEPTH = 8;
  localparam int unsigned BURST_IDX_W = $clog2(BURST_DEPTH);
  localparam int unsigned BURST_CNT_W = BURST_IDX_W + 1;

  // Input operations
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  // MUS event types (descriptor bits 6:4)
  localparam logic [2:0] EV_RELEASE = 3'd0;
  localparam logic [2:0] EV_PRESS   = 3'd1;
  localparam logic [2:0] EV_PITCH   = 3'd2;
  localparam logic [2:0] EV_SYSTEM  = 3'd3;
  localparam logic [2:0] EV_CONTROL = 3'd4;
  localparam logic [2:0] EV_END     = 3'd6;

  // MIDI status and meta bytes
  localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
  localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
  localparam logic [7:0] MIDI_CTRL     = 8'hB0;
  localparam logic [7:0] MIDI_PROG     = 8'hC0;
  localparam logic [7:0] MIDI_BEND     = 8'hE0;
  localparam logic [7:0] MIDI_META     = 8'hFF;
  localparam logic [7:0] MIDI_EOT      = 8'h2F;
  localparam logic [7:0] MIDI_ZERO     = 8'h00;
  localparam logic [7:0] MIDI_DATA_MAX = 8'h7F;

  // Channel mapping
  localparam logic [3:0] MUS_PERC_CH  = 4'd15;
  localparam logic [3:0] MIDI_PERC_CH = 4'd9;
  localparam logic [4:0] PERC_SLOT    = 5'd9;
  localparam logic [4:0] PERC_SKIP    = 5'd10;
  localparam logic [4:0] UNASSIGNED   = 5'h10;
  localparam logic [6:0] VEL_DEFAULT  = 7'd127;

  // Argument ranges
  localparam logic [7:0] SYS_FIRST   = 8'd10;
  localparam logic [7:0] SYS_LAST    = 8'd14;
  localparam logic [7:0] CTRL_NUM_MAX = 8'd15;
  localparam logic [3:0] CTRL_CLAMP  = 4'd15;
  localparam logic [3:0] CTRL_LAST   = 4'd9;
  localparam logic [3:0] CTRL_PROG   = 4'd0;

  typedef enum logic [1:0] {
    ST_TRACK  = 2'd0,
    ST_FINAL  = 2'd1,
    ST_FAILED = 2'd2
  } status_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       end_of_lump;
  } in_word_t;

  typedef struct packed {
    logic [BURST_DEPTH-1:0][7:0] bytes;
    logic [BURST_CNT_W-1:0]      count;
    status_e                     last_status;
    logic [31:0]                 track_length;
  } burst_t;

  // MUS controller / system event number to MIDI controller number
  function automatic logic [7:0] ctrl_map(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h00;
      4'd1:    r = 8'h20;
      4'd2:    r = 8'h01;
      4'd3:    r = 8'h07;
      4'd4:    r = 8'h0A;
      4'd5:    r = 8'h0B;
      4'd6:    r = 8'h5B;
      4'd7:    r = 8'h5D;
      4'd8:    r = 8'h40;
      4'd9:    r = 8'h43;
      4'd10:   r = 8'h78;
      4'd11:   r = 8'h7B;
      4'd12:   r = 8'h7E;
      4'd13:   r = 8'h7F;
      4'd14:   r = 8'h79;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/mtm_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_stream_if
// Valid/ready channels for score words in and track words out.
// ----------------------------------------------------------------------------
interface mtm_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       end_of_lump;

  modport source (output valid, output operation, output data_byte,
                  output end_of_lump, input ready);
  modport sink   (input valid, input operation, input data_byte,
                  input end_of_lump, output ready);
endinterface

interface mtm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  midi_byte;
  logic [1:0]  status;
  logic [31:0] track_length;
  logic        last_in_run;

  modport source (output valid, output midi_byte, output status,
                  output track_length, output last_in_run, input ready);
  modport sink   (input valid, input midi_byte, input status,
                  input track_length, input last_in_run, output ready);
endinterface

>>> rtl/music_event_to_midi_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_event_to_midi_stream
// MUS score bytes in, MIDI track bytes out.
// ----------------------------------------------------------------------------
// Feed the score one byte per word, starting at the score start offset, after
// a begin-conversion word (operation = 1) that clears the channel map,
// velocities and queued time. Each byte yields zero to seven track bytes: a
// variable-length delta time (one to four bytes) followed by a two- or
// three-byte MIDI event. A bad event or a score that ends early yields one
// word with status 2; the score-end event yields FF 2F 00 with the last word
// flagged status 1 and carrying the total track length. Later bytes are
// dropped until the next begin word. Timing: a byte is parsed while it sits
// in the input register, and its first track byte is offered in the cycle
// after the parser takes it. Bytes that produce nothing (descriptors, delay
// bytes, the first byte of a two-byte argument) are taken one per cycle, even
// while earlier track bytes are still draining. A byte that produces track
// bytes holds the output until they have drained, since the output port moves
// one byte per cycle while the receiver is ready, and the next byte that
// produces output waits until the last of them is accepted. The sustained
// rate is set by that port.
// ----------------------------------------------------------------------------
module music_event_to_midi_stream #(
  parameter int unsigned TIME_WIDTH = mtm_pkg::TIME_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtm_in_if.sink    in_i,
  mtm_out_if.source out_o
);
  import mtm_pkg::*;

  logic     word_valid;
  in_word_t word;
  logic     word_take;

  logic     burst_valid;
  burst_t   burst;
  logic     burst_ready;

  // Input register: decouples upstream from the parser.
  mtm_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (word_valid),
    .word_o  (word),
    .take_i  (word_take)
  );

  // Parser: all per-byte work in one pass, builds a burst of track bytes.
  mtm_parser #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_valid_i  (word_valid),
    .word_i        (word),
    .take_o        (word_take),
    .burst_valid_o (burst_valid),
    .burst_o       (burst),
    .burst_ready_i (burst_ready)
  );

  // Result register: drains a burst one word per cycle while the receiver is ready.
  mtm_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_valid_i (burst_valid),
    .burst_i       (burst),
    .burst_ready_o (burst_ready),
    .out_o         (out_o)
  );

endmodule

>>> rtl/mtm_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_in_stage
// Input register: holds one score word until the parser takes it.
// ----------------------------------------------------------------------------
module mtm_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  mtm_in_if.sink           in_i,
  output logic             valid_o,
  output mtm_pkg::in_word_t word_o,
  input  logic             take_i
);
  import mtm_pkg::*;

  logic     full_q;
  in_word_t word_q;

  assign in_i.ready = !full_q || take_i;
  assign valid_o    = full_q;
  assign word_o     = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      full_q <= 1'b1;
    end else if (take_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      word_q.operation   <= in_i.operation;
      word_q.data_byte   <= in_i.data_byte;
      word_q.end_of_lump <= in_i.end_of_lump;
    end
  end

endmodule

>>> rtl/mtm_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_parser
// Score parser: channel map, velocities, delay queue, and burst build.
// ----------------------------------------------------------------------------
module mtm_parser #(
  parameter int unsigned TIME_WIDTH = mtm_pkg::TIME_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              word_valid_i,
  input  mtm_pkg::in_word_t word_i,
  output logic              take_o,
  output logic              burst_valid_o,
  output mtm_pkg::burst_t   burst_o,
  input  logic              burst_ready_i
);
  import mtm_pkg::*;

  typedef enum logic [2:0] {
    PH_DESC  = 3'd0,
    PH_ARG   = 3'd1,
    PH_VEL   = 3'd2,
    PH_CVAL  = 3'd3,
    PH_DELAY = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    RUN_RUNNING = 2'd0,
    RUN_DONE    = 2'd1,
    RUN_FAILED  = 2'd2
  } run_e;

  phase_e                phase_q, phase_d;
  run_e                  run_q, run_d;
  logic [15:0][4:0]      chan_q, chan_d;
  logic [4:0]            free_q, free_d;
  logic [15:0][6:0]      vel_q, vel_d;
  logic [TIME_WIDTH-1:0] queued_q, queued_d;
  logic [TIME_WIDTH-1:0] acc_q, acc_d;
  logic [7:0]            cur_event_q, cur_event_d;
  logic [6:0]            pend_key_q, pend_key_d;
  logic [3:0]            pend_ctrl_q, pend_ctrl_d;
  logic [31:0]           track_q, track_d;

  logic [7:0] b;
  logic       act;
  logic [2:0] ev;

  // channel map lookup
  logic [3:0] map_idx;
  logic [4:0] map_entry;
  logic [4:0] map_free;
  logic       map_new;
  logic [3:0] map_ch;
  logic [6:0] vel_rd;

  // delay arithmetic
  logic                  acc_sat;
  logic [TIME_WIDTH-1:0] acc_new;
  logic [TIME_WIDTH:0]   q_sum_w;
  logic [TIME_WIDTH-1:0] q_sum;

  // event decode
  logic       fire, three, bad, end_hit, ev_done;
  logic       to_arg, to_vel, to_cval, vel_wr;
  logic [7:0] ev_a, ev_b, ev_c;
  logic       fail, need_burst;

  // delta time
  logic [VLQ_W-1:0]                     t_ext;
  logic [VLQ_GROUPS-1:0][VLQ_BITS-1:0]  grp;
  logic [VLQ_GROUPS-1:0][7:0]           ord;
  logic [BURST_IDX_W-1:0]               nt;
  logic [BURST_CNT_W-1:0]               burst_cnt;

  assign b   = word_i.data_byte;
  assign act = word_valid_i && (word_i.operation == OP_BYTE) && (run_q == RUN_RUNNING);
  assign ev  = (phase_q == PH_DESC) ? b[6:4] : cur_event_q[6:4];

  always_comb begin : chan_map
    map_idx   = (phase_q == PH_DESC) ? b[3:0] : cur_event_q[3:0];
    map_entry = chan_q[map_idx];
    map_free  = (free_q == PERC_SLOT) ? PERC_SKIP : free_q;
    map_new   = 1'b0;
    if (map_idx == MUS_PERC_CH) begin
      map_ch = MIDI_PERC_CH;
    end else if (map_entry[4]) begin
      map_ch  = map_free[3:0];
      map_new = 1'b1;
    end else begin
      map_ch = map_entry[3:0];
    end
    vel_rd = vel_q[map_ch];
  end

  always_comb begin : delay_math
    acc_sat = |acc_q[TIME_WIDTH-1 -: VLQ_BITS];
    acc_new = acc_sat ? '1 : {acc_q[TIME_WIDTH-VLQ_BITS-1:0], b[VLQ_BITS-1:0]};
    q_sum_w = {1'b0, queued_q} + {1'b0, acc_new};
    q_sum   = q_sum_w[TIME_WIDTH] ? '1 : q_sum_w[TIME_WIDTH-1:0];
  end

  always_comb begin : decode
    fire    = 1'b0;
    three   = 1'b1;
    bad     = 1'b0;
    end_hit = 1'b0;
    ev_done = 1'b0;
    to_arg  = 1'b0;
    to_vel  = 1'b0;
    to_cval = 1'b0;
    vel_wr  = 1'b0;
    ev_a    = MIDI_ZERO;
    ev_b    = MIDI_ZERO;
    ev_c    = MIDI_ZERO;
    unique case (phase_q)
      PH_DESC: begin
        if (ev <= EV_CONTROL) begin
          to_arg = 1'b1;
        end else if (ev == EV_END) begin
          fire    = 1'b1;
          end_hit = 1'b1;
          ev_a    = MIDI_META;
          ev_b    = MIDI_EOT;
          ev_c    = MIDI_ZERO;
        end else begin
          bad = 1'b1;
        end
      end
      PH_ARG: begin
        case (ev)
          EV_RELEASE: begin
            fire    = 1'b1;
            ev_done = 1'b1;
            ev_a    = MIDI_NOTE_OFF | {4'h0, map_ch};
            ev_b    = b & MIDI_DATA_MAX;
          end
          EV_PRESS: begin
            if (b[7]) begin
              to_vel = 1'b1;
            end else begin
              fire    = 1'b1;
              ev_done = 1'b1;
              ev_a    = MIDI_NOTE_ON | {4'h0, map_ch};
              ev_b    = b & MIDI_DATA_MAX;
              ev_c    = {1'b0, vel_rd};
            end
          end
          EV_PITCH: begin
            fire    = 1'b1;
            ev_done = 1'b1;
            ev_a    = MIDI_BEND | {4'h0, map_ch};
            ev_b    = {1'b0, b[0], 6'b0};
            ev_c    = {1'b0, b[7:1]};
          end
          EV_SYSTEM: begin
            if (b < SYS_FIRST || b > SYS_LAST) begin
              bad = 1'b1;
            end else begin
              fire    = 1'b1;
              ev_done = 1'b1;
              ev_a    = MIDI_CTRL | {4'h0, map_ch};
              ev_b    = ctrl_map(b[3:0]);
            end
          end
          default: begin
            to_cval = 1'b1;
          end
        endcase
      end
      PH_VEL: begin
        fire    = 1'b1;
        ev_done = 1'b1;
        vel_wr  = 1'b1;
        ev_a    = MIDI_NOTE_ON | {4'h0, map_ch};
        ev_b    = {1'b0, pend_key_q};
        ev_c    = {1'b0, b[6:0]};
      end
      PH_CVAL: begin
        if (pend_ctrl_q == CTRL_PROG) begin
          fire    = 1'b1;
          ev_done = 1'b1;
          three   = 1'b0;
          ev_a    = MIDI_PROG | {4'h0, map_ch};
          ev_b    = b & MIDI_DATA_MAX;
        end else if (pend_ctrl_q <= CTRL_LAST) begin
          fire    = 1'b1;
          ev_done = 1'b1;
          ev_a    = MIDI_CTRL | {4'h0, map_ch};
          ev_b    = ctrl_map(pend_ctrl_q);
          ev_c    = b[7] ? MIDI_DATA_MAX : b;
        end else begin
          bad = 1'b1;
        end
      end
      PH_DELAY: begin
      end
      default: begin
      end
    endcase
  end

  assign fail       = act && (bad || (word_i.end_of_lump && !end_hit));
  assign need_burst = act && (fail || fire);
  assign take_o     = word_valid_i && (!need_burst || burst_ready_i);
  assign burst_valid_o = word_valid_i && need_burst;

  // delta-time groups, most significant first, continuation bit on all but last
  always_comb begin : vlq
    t_ext = VLQ_W'(queued_q);
    for (int j = 0; j < VLQ_GROUPS; j++) begin
      grp[j] = t_ext[j*VLQ_BITS +: VLQ_BITS];
      ord[j] = MIDI_ZERO;
    end
    if (|grp[3]) begin
      nt = BURST_IDX_W'(4);
    end else if (|grp[2]) begin
      nt = BURST_IDX_W'(3);
    end else if (|grp[1]) begin
      nt = BURST_IDX_W'(2);
    end else begin
      nt = BURST_IDX_W'(1);
    end
    case (nt)
      BURST_IDX_W'(1): begin
        ord[0] = {1'b0, grp[0]};
      end
      BURST_IDX_W'(2): begin
        ord[0] = {1'b1, grp[1]};
        ord[1] = {1'b0, grp[0]};
      end
      BURST_IDX_W'(3): begin
        ord[0] = {1'b1, grp[2]};
        ord[1] = {1'b1, grp[1]};
        ord[2] = {1'b0, grp[0]};
      end
      default: begin
        ord[0] = {1'b1, grp[3]};
        ord[1] = {1'b1, grp[2]};
        ord[2] = {1'b1, grp[1]};
        ord[3] = {1'b0, grp[0]};
      end
    endcase
    burst_cnt = {1'b0, nt} + (three ? BURST_CNT_W'(3) : BURST_CNT_W'(2));
  end

  always_comb begin : burst_build
    burst_o.bytes        = '0;
    burst_o.count        = burst_cnt;
    burst_o.last_status  = ST_TRACK;
    burst_o.track_length = '0;
    if (fail) begin
      burst_o.count       = BURST_CNT_W'(1);
      burst_o.last_status = ST_FAILED;
    end else begin
      for (int j = 0; j < VLQ_GROUPS; j++) begin
        if (BURST_IDX_W'(j) < nt) begin
          burst_o.bytes[j] = ord[j];
        end
      end
      burst_o.bytes[nt]                  = ev_a;
      burst_o.bytes[nt + BURST_IDX_W'(1)] = ev_b;
      if (three) begin
        burst_o.bytes[nt + BURST_IDX_W'(2)] = ev_c;
      end
      if (end_hit) begin
        burst_o.last_status  = ST_FINAL;
        burst_o.track_length = track_q + 32'(burst_cnt);
      end
    end
  end

  always_comb begin : next_state
    phase_d     = phase_q;
    run_d       = run_q;
    chan_d      = chan_q;
    free_d      = free_q;
    vel_d       = vel_q;
    queued_d    = queued_q;
    acc_d       = acc_q;
    cur_event_d = cur_event_q;
    pend_key_d  = pend_key_q;
    pend_ctrl_d = pend_ctrl_q;
    track_d     = track_q;
    if (take_o) begin
      if (word_i.operation == OP_BEGIN) begin
        phase_d     = PH_DESC;
        run_d       = RUN_RUNNING;
        chan_d      = {16{UNASSIGNED}};
        free_d      = '0;
        vel_d       = {16{VEL_DEFAULT}};
        queued_d    = '0;
        acc_d       = '0;
        cur_event_d = '0;
        pend_key_d  = '0;
        pend_ctrl_d = '0;
        track_d     = '0;
      end else if (act) begin
        if (fail) begin
          run_d = RUN_FAILED;
        end else begin
          if (phase_q != PH_DELAY && map_new) begin
            chan_d[map_idx] = map_free;
            free_d          = map_free + 5'd1;
          end
          if (phase_q == PH_DESC) begin
            cur_event_d = b;
          end
          if (fire) begin
            queued_d = '0;
            track_d  = track_q + 32'(burst_cnt);
          end
          if (to_arg) begin
            phase_d = PH_ARG;
          end
          if (to_vel) begin
            phase_d    = PH_VEL;
            pend_key_d = b[6:0];
          end
          if (to_cval) begin
            phase_d     = PH_CVAL;
            pend_ctrl_d = (b > CTRL_NUM_MAX) ? CTRL_CLAMP : b[3:0];
          end
          if (vel_wr) begin
            vel_d[map_ch] = b[6:0];
          end
          if (ev_done) begin
            phase_d = cur_event_q[7] ? PH_DELAY : PH_DESC;
            acc_d   = '0;
          end
          if (phase_q == PH_DELAY) begin
            if (b[7]) begin
              acc_d = acc_new;
            end else begin
              queued_d = q_sum;
              acc_d    = '0;
              phase_d  = PH_DESC;
            end
          end
          if (end_hit) begin
            run_d = RUN_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DESC;
      run_q       <= RUN_RUNNING;
      chan_q      <= {16{UNASSIGNED}};
      free_q      <= '0;
      vel_q       <= {16{VEL_DEFAULT}};
      queued_q    <= '0;
      acc_q       <= '0;
      cur_event_q <= '0;
      pend_key_q  <= '0;
      pend_ctrl_q <= '0;
      track_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      run_q       <= run_d;
      chan_q      <= chan_d;
      free_q      <= free_d;
      vel_q       <= vel_d;
      queued_q    <= queued_d;
      acc_q       <= acc_d;
      cur_event_q <= cur_event_d;
      pend_key_q  <= pend_key_d;
      pend_ctrl_q <= pend_ctrl_d;
      track_q     <= track_d;
    end
  end

endmodule

>>> rtl/mtm_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtm_serializer
// Result register: holds one burst and sends it out one word at a time.
// ----------------------------------------------------------------------------
module mtm_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            burst_valid_i,
  input  mtm_pkg::burst_t burst_i,
  output logic            burst_ready_o,
  mtm_out_if.source       out_o
);
  import mtm_pkg::*;

  logic                   busy_q;
  burst_t                 buf_q;
  logic [BURST_IDX_W-1:0] idx_q;
  logic                   last;

  assign last = ({1'b0, idx_q} + BURST_CNT_W'(1)) == buf_q.count;

  assign out_o.valid        = busy_q;
  assign out_o.midi_byte    = buf_q.bytes[idx_q];
  assign out_o.status       = last ? buf_q.last_status : ST_TRACK;
  assign out_o.track_length = last ? buf_q.track_length : 32'd0;
  assign out_o.last_in_run  = last;

  assign burst_ready_o = !busy_q || (out_o.ready && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (burst_valid_i && burst_ready_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && out_o.ready) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + BURST_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (burst_valid_i && burst_ready_o) begin
      buf_q <= burst_i;
    end
  end

endmodule

>>> verif/music_event_to_midi_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_event_to_midi_stream_tb
// Self-checking bench for the MUS score to MIDI track byte converter.
// A queue of score words feeds a bursty driver; a monitor predicts the track
// words of every accepted score word and checks each output word in order
// against them. The receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module music_event_to_midi_stream_tb;
  import mtm_pkg::*;

  localparam int unsigned TIME_W         = TIME_WIDTH_DEF;
  localparam logic [63:0] TICKS_MAX      = (64'd1 << TIME_W) - 64'd1;
  localparam int unsigned RANDOM_ITEMS   = 330;
  localparam int unsigned DRAIN_AT       = 250;     // random items before the drain pause
  localparam int unsigned HOLDOFF_AT     = 120;     // words taken before the long stall
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  // MUS event codes that the block must reject
  localparam logic [2:0] EV_BAD_A = 3'd5;
  localparam logic [2:0] EV_BAD_B = 3'd7;

  // MUS controller / system number to MIDI controller number
  localparam logic [7:0] MIDI_CTRL_OF [15] = '{
    8'h00, 8'h20, 8'h01, 8'h07, 8'h0A, 8'h0B, 8'h5B, 8'h5D,
    8'h40, 8'h43, 8'h78, 8'h7B, 8'h7E, 8'h7F, 8'h79
  };

  typedef enum logic [2:0] {PS_DESC, PS_ARG, PS_VEL, PS_CVAL, PS_DELAY} parse_step_e;
  typedef enum logic [1:0] {CONV_RUN, CONV_DONE, CONV_FAIL} conv_state_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_e;

  typedef struct packed {
    logic [7:0]  midi_byte;
    status_e     status;
    logic [31:0] track_length;
    logic        last_in_run;
  } track_word_t;

  typedef struct packed {
    in_word_t w;
    logic     drain_first;   // hold this word back until every result is in
  } stim_word_t;

  logic clk_i;
  logic rst_ni;

  mtm_in_if  in_bus ();
  mtm_out_if out_bus ();

  music_event_to_midi_stream uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the converter
  // --------------------------------------------------------------------------
  parse_step_e       parse_step;
  logic [4:0]        chan_map [16];
  logic [4:0]        next_free_ch;
  logic [6:0]        chan_vel [16];
  logic [TIME_W-1:0] queued_ticks;
  logic [TIME_W-1:0] delay_ticks;
  logic [7:0]        cur_event;
  logic [7:0]        held_key;
  logic [3:0]        held_ctrl;
  logic [31:0]       bytes_in_track;
  conv_state_e       conv_state;

  track_word_t run_words [$];        // words caused by the score byte in hand
  track_word_t track_words_due [$];  // predicted words not yet seen at the output

  stim_word_t  stim_q [$];
  int unsigned words_issued = 0;
  int unsigned words_taken  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned ignored_items = 0;
  logic        drain_next = 1'b0;

  function automatic void clear_conversion();
    parse_step = PS_DESC;
    for (int i = 0; i < 16; i++) begin
      chan_map[i] = UNASSIGNED;
      chan_vel[i] = VEL_DEFAULT;
    end
    next_free_ch   = '0;
    queued_ticks   = '0;
    delay_ticks    = '0;
    cur_event      = '0;
    held_key       = '0;
    held_ctrl      = '0;
    bytes_in_track = '0;
    conv_state     = CONV_RUN;
  endfunction

  function automatic void put_track_byte(input logic [7:0] value);
    track_word_t t;
    t.midi_byte    = value;
    t.status       = ST_TRACK;
    t.track_length = '0;
    t.last_in_run  = 1'b0;
    if (run_words.size() < BURST_DEPTH) begin
      run_words.push_back(t);
      bytes_in_track++;
    end
  endfunction

  // Delta time as a variable-length quantity, then the event bytes.
  function automatic void put_event(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c, input logic three);
    logic [TIME_W-1:0] t;
    logic [7:0]        grp [4];
    int                n;
    t      = queued_ticks;
    grp[0] = {1'b0, t[6:0]};
    n      = 1;
    t      = t >> 7;
    while (t != 0 && n < 4) begin
      grp[n] = {1'b1, t[6:0]};
      n++;
      t = t >> 7;
    end
    while (n > 0) begin
      n--;
      put_track_byte(grp[n]);
    end
    queued_ticks = '0;
    put_track_byte(a);
    put_track_byte(b);
    if (three) put_track_byte(c);
  endfunction

  // Percussion is fixed; other channels take the next free slot, skipping it.
  function automatic logic [3:0] map_channel(input logic [3:0] mus_ch);
    logic [4:0] slot;
    if (mus_ch == MUS_PERC_CH) return MIDI_PERC_CH;
    if ((chan_map[mus_ch] & UNASSIGNED) != 0) begin
      slot = next_free_ch;
      if (slot == PERC_SLOT) slot = PERC_SKIP;
      chan_map[mus_ch] = slot;
      next_free_ch     = slot + 5'd1;
    end
    return chan_map[mus_ch][3:0];
  endfunction

  function automatic void finish_event();
    parse_step  = cur_event[7] ? PS_DELAY : PS_DESC;
    delay_ticks = '0;
  endfunction

  // Returns 0 on a bad event.
  function automatic logic parse_score_byte(input logic [7:0] b);
    logic [3:0]  ch;
    logic [2:0]  ev;
    logic [63:0] sum;
    logic        ok;
    track_word_t t;
    ok = 1'b1;
    case (parse_step)
      PS_DESC: begin
        cur_event = b;
        void'(map_channel(b[3:0]));
        ev = b[6:4];
        if (ev <= EV_CONTROL) begin
          parse_step = PS_ARG;
        end else if (ev == EV_END) begin
          put_event(MIDI_META, MIDI_EOT, MIDI_ZERO, 1'b1);
          if (run_words.size() != 0) begin
            t              = run_words.pop_back();
            t.status       = ST_FINAL;
            t.track_length = bytes_in_track;
            run_words.push_back(t);
          end
          conv_state = CONV_DONE;
        end else begin
          ok = 1'b0;
        end
      end
      PS_ARG: begin
        ch = map_channel(cur_event[3:0]);
        ev = cur_event[6:4];
        case (ev)
          EV_RELEASE: begin
            put_event(MIDI_NOTE_OFF | 8'(ch), {1'b0, b[6:0]}, MIDI_ZERO, 1'b1);
            finish_event();
          end
          EV_PRESS: begin
            if (b[7]) begin
              held_key   = b;
              parse_step = PS_VEL;
            end else begin
              put_event(MIDI_NOTE_ON | 8'(ch), {1'b0, b[6:0]}, {1'b0, chan_vel[ch]}, 1'b1);
              finish_event();
            end
          end
          EV_PITCH: begin
            put_event(MIDI_BEND | 8'(ch), {1'b0, b[0], 6'd0}, {1'b0, b[7:1]}, 1'b1);
            finish_event();
          end
          EV_SYSTEM: begin
            if (b < SYS_FIRST || b > SYS_LAST) begin
              ok = 1'b0;
            end else begin
              put_event(MIDI_CTRL | 8'(ch), MIDI_CTRL_OF[b[3:0]], MIDI_ZERO, 1'b1);
              finish_event();
            end
          end
          default: begin
            held_ctrl  = (b > CTRL_NUM_MAX) ? CTRL_CLAMP : b[3:0];
            parse_step = PS_CVAL;
          end
        endcase
      end
      PS_VEL: begin
        ch           = map_channel(cur_event[3:0]);
        chan_vel[ch] = b[6:0];
        put_event(MIDI_NOTE_ON | 8'(ch), {1'b0, held_key[6:0]}, {1'b0, chan_vel[ch]}, 1'b1);
        finish_event();
      end
      PS_CVAL: begin
        ch = map_channel(cur_event[3:0]);
        if (held_ctrl == CTRL_PROG) begin
          put_event(MIDI_PROG | 8'(ch), {1'b0, b[6:0]}, MIDI_ZERO, 1'b0);
          finish_event();
        end else if (held_ctrl <= CTRL_LAST) begin
          // controller values with the top bit set clamp to the data maximum
          put_event(MIDI_CTRL | 8'(ch), MIDI_CTRL_OF[held_ctrl],
                    b[7] ? MIDI_DATA_MAX : b, 1'b1);
          finish_event();
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
        // delay bytes: 7 bits each, top bit means more follow; both saturate
        sum         = ({{(64 - TIME_W){1'b0}}, delay_ticks} << 7) + 64'(b[6:0]);
        delay_ticks = (sum > TICKS_MAX) ? TICKS_MAX[TIME_W-1:0] : sum[TIME_W-1:0];
        if (!b[7]) begin
          sum          = 64'(queued_ticks) + 64'(delay_ticks);
          queued_ticks = (sum > TICKS_MAX) ? TICKS_MAX[TIME_W-1:0] : sum[TIME_W-1:0];
          delay_ticks  = '0;
          parse_step   = PS_DESC;
        end
      end
    endcase
    return ok;
  endfunction

  task automatic predict_word(input in_word_t w);
    logic        ok;
    track_word_t t;
    if (w.operation == OP_BEGIN) begin
      clear_conversion();
    end else if (conv_state == CONV_RUN) begin
      run_words.delete();
      ok = parse_score_byte(w.data_byte);
      // end of data short of the score-end event is a truncated score
      if (ok && conv_state != CONV_DONE && w.end_of_lump) ok = 1'b0;
      if (!ok) begin
        conv_state     = CONV_FAIL;
        t.midi_byte    = '0;
        t.status       = ST_FAILED;
        t.track_length = '0;
        t.last_in_run  = 1'b1;
        track_words_due.push_back(t);
      end else if (run_words.size() != 0) begin
        t             = run_words.pop_back();
        t.last_in_run = 1'b1;
        run_words.push_back(t);
        foreach (run_words[i]) track_words_due.push_back(run_words[i]);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic queue_word(input logic op, input logic [7:0] data, input logic eol);
    stim_word_t s;
    s.w.operation   = op;
    s.w.data_byte   = data;
    s.w.end_of_lump = eol;
    s.drain_first   = drain_next;
    drain_next      = 1'b0;
    stim_q.push_back(s);
  endtask

  // Bytes sent after a finish or failure; the block drops them.
  task automatic queue_ignored(input int unsigned n);
    repeat (n) queue_word(OP_BYTE, 8'($urandom), 1'($urandom));
    ignored_items += n;
  endtask

  // One well-formed event, with a delay after it when the last flag is set.
  task automatic queue_event(input logic [3:0] ch, input logic last);
    int unsigned pick;
    int unsigned n_delay;
    logic [7:0]  arg;
    pick = $urandom_range(0, 99);
    arg  = 8'($urandom);
    if (pick < 22) begin
      queue_word(OP_BYTE, {last, EV_RELEASE, ch}, 1'b0);
      queue_word(OP_BYTE, arg, 1'b0);
    end else if (pick < 50) begin
      queue_word(OP_BYTE, {last, EV_PRESS, ch}, 1'b0);
      queue_word(OP_BYTE, arg, 1'b0);
      if (arg[7]) queue_word(OP_BYTE, 8'($urandom), 1'b0);
    end else if (pick < 62) begin
      queue_word(OP_BYTE, {last, EV_PITCH, ch}, 1'b0);
      queue_word(OP_BYTE, arg, 1'b0);
    end else if (pick < 72) begin
      queue_word(OP_BYTE, {last, EV_SYSTEM, ch}, 1'b0);
      queue_word(OP_BYTE, 8'($urandom_range(SYS_FIRST, SYS_LAST)), 1'b0);
    end else begin
      queue_word(OP_BYTE, {last, EV_CONTROL, ch}, 1'b0);
      queue_word(OP_BYTE, 8'($urandom_range(0, CTRL_LAST)), 1'b0);
      queue_word(OP_BYTE, arg, 1'b0);
    end
    if (last) begin
      // mostly short delays, now and then long enough to saturate
      n_delay = ($urandom_range(0, 11) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
      repeat (n_delay - 1) queue_word(OP_BYTE, {1'b1, 7'($urandom)}, 1'b0);
      queue_word(OP_BYTE, {1'b0, 7'($urandom)}, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, cycle counter and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout, %0d track words still due", $time, track_words_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of score words with random gaps, changes on falling edge
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : drive_words
    logic       nxt_valid;
    in_word_t   nxt;
    stim_word_t s;
    nxt_valid       = in_bus.valid;
    nxt.operation   = in_bus.operation;
    nxt.data_byte   = in_bus.data_byte;
    nxt.end_of_lump = in_bus.end_of_lump;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!in_bus.valid || words_taken == words_issued) begin
      // previous word is gone (or none was offered): gap, pause, or next word
      nxt_valid = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (stim_q.size() != 0 &&
                   !(stim_q[0].drain_first && track_words_due.size() != 0)) begin
        s         = stim_q.pop_front();
        nxt       = s.w;
        nxt_valid = 1'b1;
        words_issued++;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_bus.valid       <= nxt_valid;
    in_bus.operation   <= nxt.operation;
    in_bus.data_byte   <= nxt.data_byte;
    in_bus.end_of_lump <= nxt.end_of_lump;
  end

  // --------------------------------------------------------------------------
  // Receiver: ready pattern switches mode now and then; one long hold-off
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick      = 0;
  int unsigned holdoff_left = 0;
  logic        holdoff_used = 1'b0;

  always @(negedge clk_i) begin : drive_ready
    logic take;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 96);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   take = 1'b1;
      RX_COIN:   take = 1'($urandom);
      RX_MOSTLY: take = ($urandom_range(0, 7) != 0);
      default:   take = (rx_tick % 3 == 0);
    endcase
    // long stall while the sender keeps going, so the block backs up
    if (!holdoff_used && words_taken >= HOLDOFF_AT) begin
      holdoff_used = 1'b1;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      take = 1'b0;
    end
    out_bus.ready <= take;
  end

  // --------------------------------------------------------------------------
  // Monitor: check output words first, then predict from the accepted input
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_words
    track_word_t got;
    track_word_t want;
    in_word_t    w;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        got.midi_byte    = out_bus.midi_byte;
        got.status       = status_e'(out_bus.status);
        got.track_length = out_bus.track_length;
        got.last_in_run  = out_bus.last_in_run;
        if (track_words_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word: byte %h status %0d length %0d last %b",
                   $time, got.midi_byte, got.status, got.track_length, got.last_in_run);
        end else begin
          want = track_words_due.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: expected byte %h status %0d length %0d last %b, %s %h %s %0d %s %0d %s %b",
                     $time, want.midi_byte, want.status, want.track_length,
                     want.last_in_run, "got byte", got.midi_byte, "status", got.status,
                     "length", got.track_length, "last", got.last_in_run);
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        w.operation   = in_bus.operation;
        w.data_byte   = in_bus.data_byte;
        w.end_of_lump = in_bus.end_of_lump;
        predict_word(w);
        words_taken <= words_taken + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin : run_score
    int unsigned directed_n;
    int unsigned n_events;
    int unsigned pick;
    logic [3:0]  ch;
    logic        drained;
    stim_word_t  s;

    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.operation   = OP_BYTE;
    in_bus.data_byte   = '0;
    in_bus.end_of_lump = 1'b0;
    out_bus.ready      = 1'b0;
    drained            = 1'b0;
    clear_conversion();

    // Directed: begin ignores its data, every event kind, extremes
    queue_word(OP_BEGIN, 8'hFF, 1'b1);
    queue_word(OP_BYTE, {1'b0, EV_RELEASE, 4'd0}, 1'b0);
    queue_word(OP_BYTE, 8'hFF, 1'b0);
    // percussion press with velocity, then a delay that saturates
    queue_word(OP_BYTE, {1'b1, EV_PRESS, MUS_PERC_CH}, 1'b0);
    queue_word(OP_BYTE, 8'hBC, 1'b0);
    queue_word(OP_BYTE, 8'hFF, 1'b0);
    repeat (4) queue_word(OP_BYTE, 8'hFF, 1'b0);
    queue_word(OP_BYTE, 8'h7F, 1'b0);
    // press with stored velocity carries a four-byte delta
    queue_word(OP_BYTE, {1'b0, EV_PRESS, 4'd1}, 1'b0);
    queue_word(OP_BYTE, 8'h40, 1'b0);
    queue_word(OP_BYTE, {1'b0, EV_PITCH, 4'd2}, 1'b0);
    queue_word(OP_BYTE, 8'hFF, 1'b0);
    queue_word(OP_BYTE, {1'b0, EV_SYSTEM, 4'd3}, 1'b0);
    queue_word(OP_BYTE, 8'(SYS_LAST), 1'b0);
    queue_word(OP_BYTE, {1'b0, EV_CONTROL, 4'd4}, 1'b0);
    queue_word(OP_BYTE, 8'(CTRL_PROG), 1'b0);
    queue_word(OP_BYTE, 8'hFF, 1'b0);
    queue_word(OP_BYTE, {1'b0, EV_CONTROL, 4'd5}, 1'b0);
    queue_word(OP_BYTE, 8'(CTRL_LAST), 1'b0);
    queue_word(OP_BYTE, 8'h80, 1'b0);
    queue_word(OP_BYTE, {1'b1, EV_END, 4'd0}, 1'b1);
    queue_ignored(1);
    // bad event code
    queue_word(OP_BEGIN, 8'h00, 1'b0);
    queue_word(OP_BYTE, {1'b0, EV_BAD_A, 4'd6}, 1'b0);
    // controller number out of range, seen after the value byte
    queue_word(OP_BEGIN, 8'h00, 1'b0);
    queue_word(OP_BYTE, {1'b0, EV_CONTROL, 4'd7}, 1'b0);
    queue_word(OP_BYTE, 8'hFF, 1'b0);
    queue_word(OP_BYTE, 8'h00, 1'b0);
    // score runs out mid-stream
    queue_word(OP_BEGIN, 8'h00, 1'b0);
    queue_word(OP_BYTE, {1'b0, EV_RELEASE, 4'd8}, 1'b0);
    queue_word(OP_BYTE, 8'h00, 1'b1);
    directed_n = stim_q.size();

    // Random conversions: mostly well-formed scores, some broken ones
    while (stim_q.size() < directed_n + ignored_items + RANDOM_ITEMS) begin
      if (!drained && stim_q.size() >= directed_n + ignored_items + DRAIN_AT) begin
        drained    = 1'b1;
        drain_next = 1'b1;
      end
      queue_word(OP_BEGIN, 8'($urandom), 1'($urandom));
      n_events = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 6);
      repeat (n_events) begin
        ch = ($urandom_range(0, 5) == 0) ? MUS_PERC_CH : 4'($urandom);
        queue_event(ch, 1'($urandom));
      end
      ch   = 4'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        queue_word(OP_BYTE, {1'($urandom), EV_END, ch}, 1'($urandom));
        queue_ignored($urandom_range(0, 2));
      end else if (pick < 76) begin
        queue_word(OP_BYTE, {1'($urandom), ($urandom_range(0, 1) ? EV_BAD_A : EV_BAD_B), ch},
                   1'b0);
        queue_ignored($urandom_range(0, 2));
      end else if (pick < 82) begin
        queue_word(OP_BYTE, {1'($urandom), EV_SYSTEM, ch}, 1'b0);
        queue_word(OP_BYTE, $urandom_range(0, 1) ? 8'($urandom_range(0, SYS_FIRST - 1))
                                                 : 8'($urandom_range(SYS_LAST + 1, 255)), 1'b0);
        queue_ignored($urandom_range(0, 2));
      end else if (pick < 88) begin
        queue_word(OP_BYTE, {1'($urandom), EV_CONTROL, ch}, 1'b0);
        queue_word(OP_BYTE, 8'($urandom_range(CTRL_LAST + 1, 255)), 1'b0);
        queue_word(OP_BYTE, 8'($urandom), 1'b0);
        queue_ignored($urandom_range(0, 2));
      end else if (pick < 96) begin
        // truncation: flag the end of data on a byte that is not score end
        if ($urandom_range(0, 1)) begin
          queue_event(ch, 1'($urandom));
        end else begin
          queue_word(OP_BYTE, {1'($urandom), EV_PRESS, ch}, 1'b0);
        end
        s                 = stim_q.pop_back();
        s.w.end_of_lump   = 1'b1;
        stim_q.push_back(s);
        queue_ignored($urandom_range(0, 2));
      end
      // else: conversion abandoned; the next begin word starts over
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || words_taken != words_issued) @(posedge clk_i);
    while (track_words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
